// ===== design/rbst_pkg.sv =====
package rbst_pkg;

	// width of every coordinate, parameter and window field
	localparam int COORD_W = 32;

	// configuration register index width
	localparam int CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_ORIGIN_Z = 3'd2,
		CFG_DIR_X    = 3'd3,
		CFG_DIR_Y    = 3'd4,
		CFG_DIR_Z    = 3'd5,
		CFG_T_LOWER  = 3'd6,
		CFG_T_UPPER  = 3'd7
	} cfg_idx_t;

	// input word: one box and the caller window
	typedef struct packed {
		coord_t box_low_x;
		coord_t box_low_y;
		coord_t box_low_z;
		coord_t box_high_x;
		coord_t box_high_y;
		coord_t box_high_z;
		coord_t window_start;
		coord_t window_end;
	} box_t;

	// output word
	typedef struct packed {
		logic   hit;
		coord_t enter_t;
		coord_t exit_t;
	} result_t;

	// per-bound sign information carried beside the divider
	typedef struct packed {
		logic num_neg;
		logic num_zero;
	} num_flags_t;

	// per-axis flags carried beside the dividers
	typedef struct packed {
		num_flags_t lo;
		num_flags_t hi;
		logic       den_neg;
		logic       den_zero;
	} axis_flags_t;

endpackage

// ===== design/rbst_div.sv =====
module rbst_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	// restoring division, one quotient bit per stage, msb first
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] work_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	genvar i;
	generate
		for (i = 0; i < NUM_W; i++) begin : g_stage
			logic [DEN_W-1:0] rem_in;
			logic [NUM_W-1:0] work_in;
			logic [DEN_W-1:0] den_in;
			logic [DEN_W:0]   trial;
			logic [DEN_W:0]   diff;
			logic             ge;

			if (i == 0) begin : g_first
				assign rem_in  = '0;
				assign work_in = num;
				assign den_in  = den;
			end else begin : g_next
				assign rem_in  = rem_s[i-1];
				assign work_in = work_s[i-1];
				assign den_in  = den_s[i-1];
			end

			// shift in next dividend bit and try subtracting
			assign trial = {rem_in, work_in[NUM_W-1]};
			assign diff  = trial - {1'b0, den_in};
			assign ge    = (trial >= {1'b0, den_in});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					work_s[i] <= {work_in[NUM_W-2:0], ge};
					den_s[i]  <= den_in;
				end
			end
		end
	endgenerate

	assign quo = work_s[NUM_W-1];

endmodule

// ===== design/rbst_delay.sv =====
module rbst_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld,
	input  logic [WIDTH-1:0] d,
	output logic             vld_out,
	output logic [WIDTH-1:0] q
);

	// valid bits, reset clears them
	logic [DEPTH-1:0] vld_s;
	// side data, no reset
	logic [WIDTH-1:0] line_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			if (DEPTH > 1) begin
				vld_s <= {vld_s[DEPTH-2:0], vld};
			end else begin
				vld_s[0] <= vld;
			end
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_tap
			always_ff @(posedge clk) begin
				if (en) begin
					line_s[i] <= (i == 0) ? d : line_s[(i == 0) ? 0 : i-1];
				end
			end
		end
	endgenerate

	assign vld_out = vld_s[DEPTH-1];
	assign q       = line_s[DEPTH-1];

endmodule

// ===== design/ray_box_slab_test.sv =====
// ray / axis-aligned box slab test
//
// the ray is loaded through the write port (cfg_we, cfg_index, cfg_data):
// origin x/y/z, direction x/y/z, then the least and greatest ray parameter.
// load it only while no box word is in flight.
// box words enter on box_valid/box_ready, one box and a caller window each;
// every box gives exactly one result word on res_valid/res_ready: hit,
// then the entry and exit parameter, or the echoed window on a miss.
// all values are signed fixed point with FRAC_BITS fraction bits.
// throughput: one box per cycle while the output is not stalled. most of
// the pipeline depth comes from the bit-per-stage dividers, six of which
// run side by side, one for each slab bound.
// when a result word waits and res_ready is low, the whole pipeline holds
// and box_ready drops; nothing is lost or repeated. reset empties the
// pipeline and loads origin and direction zero, lower limit zero and
// upper limit max positive.
module ray_box_slab_test #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           box_valid,
	output logic                           box_ready,
	input  rbst_pkg::box_t                 box,
	output logic                           res_valid,
	input  logic                           res_ready,
	output rbst_pkg::result_t              res,
	input  logic                           cfg_we,
	input  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbst_pkg::COORD_W-1:0]   cfg_data
);

	localparam int CW    = rbst_pkg::COORD_W;
	localparam int NW    = CW + 1 + FRAC_BITS;
	localparam int META_W = 3 * $bits(rbst_pkg::axis_flags_t) + 2 * CW;
	localparam logic [NW-1:0] NEG_LIM = NW'(1) << (CW - 1);
	localparam logic [NW-1:0] POS_LIM = NEG_LIM - NW'(1);
	localparam logic [CW-1:0] POS_SAT = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] NEG_SAT = {1'b1, {(CW-1){1'b0}}};

	// ray registers
	rbst_pkg::coord_t org_q [3];
	rbst_pkg::coord_t dir_q [3];
	rbst_pkg::coord_t t_lower_q;
	rbst_pkg::coord_t t_upper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0]  <= '0;
			org_q[1]  <= '0;
			org_q[2]  <= '0;
			dir_q[0]  <= '0;
			dir_q[1]  <= '0;
			dir_q[2]  <= '0;
			t_lower_q <= '0;
			t_upper_q <= POS_SAT;
		end else if (cfg_we) begin
			unique case (rbst_pkg::cfg_idx_t'(cfg_index))
				rbst_pkg::CFG_ORIGIN_X: org_q[0]  <= cfg_data;
				rbst_pkg::CFG_ORIGIN_Y: org_q[1]  <= cfg_data;
				rbst_pkg::CFG_ORIGIN_Z: org_q[2]  <= cfg_data;
				rbst_pkg::CFG_DIR_X:    dir_q[0]  <= cfg_data;
				rbst_pkg::CFG_DIR_Y:    dir_q[1]  <= cfg_data;
				rbst_pkg::CFG_DIR_Z:    dir_q[2]  <= cfg_data;
				rbst_pkg::CFG_T_LOWER:  t_lower_q <= cfg_data;
				rbst_pkg::CFG_T_UPPER:  t_upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the last stage is empty or being taken
	logic en;
	logic valid_s4;
	assign en        = !valid_s4 || res_ready;
	assign box_ready = en;

	// stage 1: differences and magnitudes
	rbst_pkg::coord_t lo_in [3];
	rbst_pkg::coord_t hi_in [3];
	assign lo_in[0] = box.box_low_x;
	assign lo_in[1] = box.box_low_y;
	assign lo_in[2] = box.box_low_z;
	assign hi_in[0] = box.box_high_x;
	assign hi_in[1] = box.box_high_y;
	assign hi_in[2] = box.box_high_z;

	logic                  valid_s1;
	logic [NW-1:0]         num_lo_s1 [3];
	logic [NW-1:0]         num_hi_s1 [3];
	logic [CW-1:0]         den_s1 [3];
	rbst_pkg::axis_flags_t flags_s1 [3];
	rbst_pkg::coord_t      ws_s1;
	rbst_pkg::coord_t      we_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= box_valid;
		end
	end

	genvar a;
	generate
		for (a = 0; a < 3; a++) begin : g_prep
			logic signed [CW:0] dlo;
			logic signed [CW:0] dhi;
			logic [CW:0]        mlo;
			logic [CW:0]        mhi;
			logic [CW-1:0]      mden;

			assign dlo  = {lo_in[a][CW-1], lo_in[a]} - {org_q[a][CW-1], org_q[a]};
			assign dhi  = {hi_in[a][CW-1], hi_in[a]} - {org_q[a][CW-1], org_q[a]};
			assign mlo  = dlo[CW] ? (CW+1)'(-dlo) : dlo;
			assign mhi  = dhi[CW] ? (CW+1)'(-dhi) : dhi;
			assign mden = dir_q[a][CW-1] ? CW'(-dir_q[a]) : dir_q[a];

			always_ff @(posedge clk) begin
				if (en) begin
					num_lo_s1[a]            <= {mlo, {FRAC_BITS{1'b0}}};
					num_hi_s1[a]            <= {mhi, {FRAC_BITS{1'b0}}};
					den_s1[a]               <= mden;
					flags_s1[a].lo.num_neg  <= dlo[CW];
					flags_s1[a].lo.num_zero <= (dlo == '0);
					flags_s1[a].hi.num_neg  <= dhi[CW];
					flags_s1[a].hi.num_zero <= (dhi == '0);
					flags_s1[a].den_neg     <= dir_q[a][CW-1];
					flags_s1[a].den_zero    <= (dir_q[a] == '0);
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			ws_s1 <= box.window_start;
			we_s1 <= box.window_end;
		end
	end

	// divider pipelines, one per slab bound
	logic [NW-1:0] q_lo [3];
	logic [NW-1:0] q_hi [3];

	generate
		for (a = 0; a < 3; a++) begin : g_div
			rbst_div #(.NUM_W(NW), .DEN_W(CW)) u_div_lo (
				.clk (clk),
				.en  (en),
				.num (num_lo_s1[a]),
				.den (den_s1[a]),
				.quo (q_lo[a])
			);
			rbst_div #(.NUM_W(NW), .DEN_W(CW)) u_div_hi (
				.clk (clk),
				.en  (en),
				.num (num_hi_s1[a]),
				.den (den_s1[a]),
				.quo (q_hi[a])
			);
		end
	endgenerate

	// side data delayed to match the dividers
	logic              meta_vld;
	logic [META_W-1:0] meta_q;
	rbst_pkg::axis_flags_t flags_d [3];
	rbst_pkg::coord_t      ws_d;
	rbst_pkg::coord_t      we_d;

	rbst_delay #(.WIDTH(META_W), .DEPTH(NW)) u_meta (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (valid_s1),
		.d       ({flags_s1[0], flags_s1[1], flags_s1[2], ws_s1, we_s1}),
		.vld_out (meta_vld),
		.q       (meta_q)
	);

	assign {flags_d[0], flags_d[1], flags_d[2], ws_d, we_d} = meta_q;

	// saturate a magnitude quotient to a signed parameter
	function automatic logic [CW-1:0] sat_quo(
		input logic [NW-1:0]      q,
		input rbst_pkg::num_flags_t nf,
		input logic               den_neg,
		input logic               den_zero,
		input logic               is_low
	);
		logic [CW-1:0] r;
		if (den_zero) begin
			if (nf.num_zero) begin
				r = is_low ? NEG_SAT : POS_SAT;
			end else begin
				r = nf.num_neg ? NEG_SAT : POS_SAT;
			end
		end else if (nf.num_neg ^ den_neg) begin
			r = (q > NEG_LIM) ? NEG_SAT : CW'(-q[CW-1:0]);
		end else begin
			r = (q > POS_LIM) ? POS_SAT : q[CW-1:0];
		end
		return r;
	endfunction

	// stage 2: saturation and swap per axis
	logic             valid_s2;
	rbst_pkg::coord_t tin_s2 [3];
	rbst_pkg::coord_t tout_s2 [3];
	rbst_pkg::coord_t ws_s2;
	rbst_pkg::coord_t we_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= meta_vld;
		end
	end

	generate
		for (a = 0; a < 3; a++) begin : g_sat
			logic [CW-1:0] ta;
			logic [CW-1:0] tb;
			assign ta = sat_quo(q_lo[a], flags_d[a].lo, flags_d[a].den_neg,
				flags_d[a].den_zero, 1'b1);
			assign tb = sat_quo(q_hi[a], flags_d[a].hi, flags_d[a].den_neg,
				flags_d[a].den_zero, 1'b0);
			always_ff @(posedge clk) begin
				if (en) begin
					tin_s2[a]  <= flags_d[a].den_neg ? tb : ta;
					tout_s2[a] <= flags_d[a].den_neg ? ta : tb;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			ws_s2 <= ws_d;
			we_s2 <= we_d;
		end
	end

	// stage 3: intersect the three slabs
	logic             valid_s3;
	rbst_pkg::coord_t enter_s3;
	rbst_pkg::coord_t leave_s3;
	rbst_pkg::coord_t ws_s3;
	rbst_pkg::coord_t we_s3;
	rbst_pkg::coord_t enter_xy;
	rbst_pkg::coord_t leave_xy;

	assign enter_xy = (tin_s2[1] > tin_s2[0]) ? tin_s2[1] : tin_s2[0];
	assign leave_xy = (tout_s2[1] < tout_s2[0]) ? tout_s2[1] : tout_s2[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			enter_s3 <= (tin_s2[2] > enter_xy) ? tin_s2[2] : enter_xy;
			leave_s3 <= (tout_s2[2] < leave_xy) ? tout_s2[2] : leave_xy;
			ws_s3    <= ws_s2;
			we_s3    <= we_s2;
		end
	end

	// stage 4: limit checks and output word
	logic              hit_c;
	rbst_pkg::result_t res_s4;

	assign hit_c = !(enter_s3 > leave_s3 || enter_s3 < ws_s3 || leave_s3 > we_s3 ||
		enter_s3 < t_lower_q || leave_s3 > t_upper_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4.hit     <= hit_c;
			res_s4.enter_t <= hit_c ? enter_s3 : ws_s3;
			res_s4.exit_t  <= hit_c ? leave_s3 : we_s3;
		end
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;

endmodule
